// ===== sv/skf_pkg.sv =====
// Shared types and constants of the spectral Kalman filter step unit.
`default_nettype none
package skf_pkg;

   localparam logic       OP_LOAD    = 1'b0;
   localparam logic       OP_OBSERVE = 1'b1;
   localparam logic [30:0] VAR_MAX   = 31'h7FFF_FFFF;
   localparam int         DIV_STEPS  = 33;
   localparam logic [30:0] OBS_NOISE_RESET = 31'd65536;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_M_AMC,
      ST_M_BMS,
      ST_M_AMS,
      ST_M_BMC,
      ST_M_AA,
      ST_M_BB,
      ST_G_SUM,
      ST_M_RGLO,
      ST_M_RGHI,
      ST_VSCALE,
      ST_R1,
      ST_DEN,
      ST_NUM,
      ST_DIV,
      ST_QSTORE,
      ST_MUL_MEAN,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      DIV_VAR,
      DIV_COS,
      DIV_SIN
   } div_tgt_type;

   typedef struct packed {
      logic               pair;
      logic signed [31:0] coef_a;
      logic signed [31:0] coef_b;
      logic [30:0]        spec;
      logic [30:0]        variance;
      logic signed [31:0] mean_c;
      logic signed [31:0] mean_s;
   } bin_entry_type;

endpackage
`default_nettype wire

// ===== sv/spectral_kalman_filter_step_unit.sv =====
// Top level: per-bin Kalman filter step over a shared multiplier and divider.
`default_nettype none
// One transaction per item, one result per item. A load or an out-of-range bin
// is answered in the cycle after acceptance. An observe runs through a single
// 33x33 multiplier and a radix-2 divider (one quotient bit per cycle, 33 quotient
// bits per division); a real bin needs two divisions and a cos/sine pair three,
// and most of the time of an observe goes to the divider. The input side is ready
// only while the unit is idle and no result is waiting. Bin state lives in an
// internal memory with no clearing; observing a bin that was never loaded gives
// undefined results.
module spectral_kalman_filter_step_unit #(
   parameter int MAX_BINS  = 256,
   parameter int FRAC_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // bin, coef_a, coef_b, prior_var, obs_cos, obs_sin, zero pad
   input  wire logic [167:0] req_tdata,
   // op, is_pair
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // pred_mean_cos, pred_mean_sin, pred_var, filt_mean_cos, filt_mean_sin,
   // filt_var, zero pad
   output logic [191:0]      rsp_tdata,
   // saturated
   output logic [0:0]        rsp_tuser,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [30:0]  csr_data
);
   import skf_pkg::*;

   localparam int ADDR_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int TWO_Q  = 2 * FRAC_BITS;
   localparam logic signed [66:0] MEAN_HALF = 67'sd1 <<< (FRAC_BITS - 1);
   localparam logic [94:0]        VAR_HALF  = 95'd1 << (TWO_Q - 1);

   function automatic logic [32:0] clip32(input logic signed [66:0] v);
      logic [32:0] res;
      if (v > 67'sd2147483647) begin
         res = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -67'sd2147483648) begin
         res = {1'b1, 32'h8000_0000};
      end else begin
         res = {1'b0, v[31:0]};
      end
      return res;
   endfunction

   // input fields
   logic               req_op;
   logic               req_is_pair;
   logic [7:0]         req_bin;
   logic signed [31:0] req_coef_a, req_coef_b, req_obs_cos, req_obs_sin;
   logic [30:0]        req_prior_var;

   assign req_op        = req_tuser[0];
   assign req_is_pair   = req_tuser[1];
   assign req_bin       = req_tdata[7:0];
   assign req_coef_a    = req_tdata[39:8];
   assign req_coef_b    = req_tdata[71:40];
   assign req_prior_var = req_tdata[102:72];
   assign req_obs_cos   = req_tdata[134:103];
   assign req_obs_sin   = req_tdata[166:135];

   state_type state_ff, state_in;
   div_tgt_type div_tgt_ff;
   logic req_fire, rsp_fire, in_range;

   logic [30:0] obs_noise_var_ff;

   bin_entry_type mem [MAX_BINS];
   bin_entry_type rd_ff, mem_wdata;
   logic [ADDR_W-1:0] addr_ff, mem_waddr;
   logic mem_we;

   logic signed [31:0] obs_c_ff, obs_s_ff;
   logic signed [32:0] mul_x_in, mul_y_in;
   logic signed [65:0] prod_ff, acc_ff;
   logic [63:0]        g_ff;
   logic [94:0]        big_ff;
   logic [30:0]        prodv_ff, r1_ff, fv_ff;
   logic [31:0]        den_ff, magc_ff, mags_ff, rem_ff;
   logic               negc_ff, negs_ff, sat_ff;
   logic [32:0]        dq_ff, qc_ff, qs_ff;
   logic [5:0]         div_cnt_ff;
   logic signed [31:0] pmc_ff, pms_ff;

   logic signed [31:0] b_w, ms_w;
   logic signed [66:0] mean_sum_w;
   logic [32:0]        mean_clip_w;
   logic [94:0]        vs_w, vs_shift_w;
   logic [31:0]        r1_sum_w;
   logic [63:0]        num_w;
   logic [32:0]        div_t_w;
   logic               div_ge_w;
   logic signed [32:0] innov_c_w, innov_s_w;
   logic signed [33:0] fmc_w, fms_w;
   logic [32:0]        fmc_clip_w, fms_clip_w;

   // result registers
   logic               rsp_valid_ff, rsp_sat_ff;
   logic signed [31:0] rsp_pmc_ff, rsp_pms_ff, rsp_fmc_ff, rsp_fms_ff;
   logic [30:0]        rsp_pv_ff, rsp_fv_ff;

   assign req_fire   = req_tvalid & req_tready;
   assign rsp_fire   = rsp_valid_ff & rsp_tready;
   assign in_range   = int'(req_bin) < MAX_BINS;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_sat_ff;
   assign rsp_tdata  = {2'b00, rsp_fv_ff, rsp_fms_ff, rsp_fmc_ff,
                        rsp_pv_ff, rsp_pms_ff, rsp_pmc_ff};

   assign b_w  = rd_ff.pair ? rd_ff.coef_b : 32'sd0;
   assign ms_w = rd_ff.pair ? rd_ff.mean_s : 32'sd0;

   // sequencer and multiplier operand select
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      mul_x_in   = '0;
      mul_y_in   = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = !rsp_valid_ff;
            if (req_fire && in_range && req_op == OP_OBSERVE) begin
               state_in = ST_M_AMC;
            end
         end
         ST_M_AMC: begin
            mul_x_in = 33'(rd_ff.coef_a);
            mul_y_in = 33'(rd_ff.mean_c);
            state_in = ST_M_BMS;
         end
         ST_M_BMS: begin
            mul_x_in = 33'(b_w);
            mul_y_in = 33'(ms_w);
            state_in = ST_M_AMS;
         end
         ST_M_AMS: begin
            mul_x_in = 33'(rd_ff.coef_a);
            mul_y_in = 33'(ms_w);
            state_in = ST_M_BMC;
         end
         ST_M_BMC: begin
            mul_x_in = 33'(b_w);
            mul_y_in = 33'(rd_ff.mean_c);
            state_in = ST_M_AA;
         end
         ST_M_AA: begin
            mul_x_in = 33'(rd_ff.coef_a);
            mul_y_in = 33'(rd_ff.coef_a);
            state_in = ST_M_BB;
         end
         ST_M_BB: begin
            mul_x_in = 33'(b_w);
            mul_y_in = 33'(b_w);
            state_in = ST_G_SUM;
         end
         ST_G_SUM:  state_in = ST_M_RGLO;
         ST_M_RGLO: begin
            mul_x_in = {2'b00, rd_ff.variance};
            mul_y_in = {1'b0, g_ff[31:0]};
            state_in = ST_M_RGHI;
         end
         ST_M_RGHI: begin
            mul_x_in = {2'b00, rd_ff.variance};
            mul_y_in = {1'b0, g_ff[63:32]};
            state_in = ST_VSCALE;
         end
         ST_VSCALE: state_in = ST_R1;
         ST_R1:     state_in = ST_DEN;
         ST_DEN: begin
            mul_x_in = {2'b00, r1_ff};
            mul_y_in = {2'b00, obs_noise_var_ff};
            state_in = ST_NUM;
         end
         ST_NUM: state_in = ST_DIV;
         ST_DIV: begin
            if (div_cnt_ff == 6'(DIV_STEPS - 1)) begin
               state_in = ST_QSTORE;
            end
         end
         ST_QSTORE: begin
            case (div_tgt_ff)
               DIV_VAR: state_in = ST_MUL_MEAN;
               DIV_COS: state_in = rd_ff.pair ? ST_MUL_MEAN : ST_FIN;
               default: state_in = ST_FIN;
            endcase
         end
         ST_MUL_MEAN: begin
            mul_x_in = {2'b00, r1_ff};
            mul_y_in = (div_tgt_ff == DIV_COS) ? {1'b0, magc_ff} : {1'b0, mags_ff};
            state_in = ST_NUM;
         end
         ST_FIN:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath arithmetic
   always_comb begin
      if (state_ff == ST_M_AA) begin
         mean_sum_w = 67'(acc_ff) - 67'(prod_ff) + MEAN_HALF;
      end else begin
         mean_sum_w = 67'(acc_ff) + 67'(prod_ff) + MEAN_HALF;
      end
      mean_clip_w = clip32(mean_sum_w >>> FRAC_BITS);
      vs_w        = big_ff + (95'(prod_ff[61:0]) << 32) + VAR_HALF;
      vs_shift_w  = vs_w >> TWO_Q;
      r1_sum_w    = {1'b0, prodv_ff} + {1'b0, rd_ff.spec};
      num_w       = prod_ff[63:0] + 64'(den_ff[31:1]);
      div_t_w     = {rem_ff, dq_ff[32]};
      div_ge_w    = div_t_w >= {1'b0, den_ff};
      innov_c_w   = 33'(obs_c_ff) - 33'(pmc_ff);
      innov_s_w   = 33'(obs_s_ff) - 33'(pms_ff);
      fmc_w = negc_ff ? 34'(pmc_ff) - 34'(signed'({1'b0, qc_ff}))
                      : 34'(pmc_ff) + 34'(signed'({1'b0, qc_ff}));
      fms_w = negs_ff ? 34'(pms_ff) - 34'(signed'({1'b0, qs_ff}))
                      : 34'(pms_ff) + 34'(signed'({1'b0, qs_ff}));
      fmc_clip_w = clip32(67'(fmc_w));
      fms_clip_w = clip32(67'(fms_w));
   end

   // memory write select
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = rd_ff;
      if (state_ff == ST_IDLE && req_fire && in_range && req_op == OP_LOAD) begin
         mem_we    = 1'b1;
         mem_waddr = ADDR_W'(req_bin);
         mem_wdata = '{pair: req_is_pair, coef_a: req_coef_a, coef_b: req_coef_b,
                       spec: req_prior_var, variance: req_prior_var,
                       mean_c: 32'sd0, mean_s: 32'sd0};
      end else if (state_ff == ST_FIN) begin
         mem_we = 1'b1;
         if (den_ff == 32'd0) begin
            mem_wdata.mean_c   = pmc_ff;
            mem_wdata.mean_s   = pms_ff;
            mem_wdata.variance = '0;
         end else begin
            mem_wdata.mean_c   = fmc_clip_w[31:0];
            mem_wdata.mean_s   = rd_ff.pair ? fms_clip_w[31:0] : 32'sd0;
            mem_wdata.variance = fv_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_ff <= mem[ADDR_W'(req_bin)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         obs_noise_var_ff <= OBS_NOISE_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            obs_noise_var_ff <= csr_data;
         end
         if ((req_fire && !(in_range && req_op == OP_OBSERVE)) || state_ff == ST_FIN) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_x_in * mul_y_in;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               addr_ff    <= ADDR_W'(req_bin);
               obs_c_ff   <= req_obs_cos;
               obs_s_ff   <= req_obs_sin;
               sat_ff     <= 1'b0;
               rsp_pmc_ff <= '0;
               rsp_pms_ff <= '0;
               rsp_pv_ff  <= '0;
               rsp_fmc_ff <= '0;
               rsp_fms_ff <= '0;
               rsp_sat_ff <= 1'b0;
               rsp_fv_ff  <= (in_range && req_op == OP_LOAD) ? req_prior_var : 31'd0;
            end
         end
         ST_M_BMS: acc_ff <= prod_ff;
         ST_M_AMS: begin
            pmc_ff <= mean_clip_w[31:0];
            sat_ff <= sat_ff | mean_clip_w[32];
         end
         ST_M_BMC: acc_ff <= prod_ff;
         ST_M_AA: begin
            pms_ff <= rd_ff.pair ? mean_clip_w[31:0] : 32'sd0;
            sat_ff <= sat_ff | (rd_ff.pair & mean_clip_w[32]);
         end
         ST_M_BB: g_ff <= prod_ff[63:0];
         ST_G_SUM: begin
            g_ff    <= g_ff + prod_ff[63:0];
            negc_ff <= innov_c_w[32];
            magc_ff <= innov_c_w[32] ? 32'(-innov_c_w) : innov_c_w[31:0];
            negs_ff <= innov_s_w[32];
            mags_ff <= innov_s_w[32] ? 32'(-innov_s_w) : innov_s_w[31:0];
         end
         ST_M_RGHI: big_ff <= 95'(prod_ff[62:0]);
         ST_VSCALE: begin
            if (vs_shift_w > 95'(VAR_MAX)) begin
               prodv_ff <= VAR_MAX;
               sat_ff   <= 1'b1;
            end else begin
               prodv_ff <= vs_shift_w[30:0];
            end
         end
         ST_R1: begin
            if (r1_sum_w[31]) begin
               r1_ff  <= VAR_MAX;
               sat_ff <= 1'b1;
            end else begin
               r1_ff <= r1_sum_w[30:0];
            end
         end
         ST_DEN: begin
            den_ff     <= {1'b0, obs_noise_var_ff} + {1'b0, r1_ff};
            div_tgt_ff <= DIV_VAR;
         end
         ST_NUM: begin
            rem_ff     <= {1'b0, num_w[63:33]};
            dq_ff      <= num_w[32:0];
            div_cnt_ff <= '0;
         end
         ST_DIV: begin
            div_cnt_ff <= div_cnt_ff + 6'd1;
            rem_ff     <= div_ge_w ? 32'(div_t_w - {1'b0, den_ff}) : div_t_w[31:0];
            dq_ff      <= {dq_ff[31:0], div_ge_w};
         end
         ST_QSTORE: begin
            case (div_tgt_ff)
               DIV_VAR: begin
                  fv_ff      <= dq_ff[30:0];
                  div_tgt_ff <= DIV_COS;
               end
               DIV_COS: begin
                  qc_ff      <= dq_ff;
                  div_tgt_ff <= DIV_SIN;
               end
               default: qs_ff <= dq_ff;
            endcase
         end
         ST_FIN: begin
            rsp_pmc_ff <= pmc_ff;
            rsp_pms_ff <= pms_ff;
            rsp_pv_ff  <= r1_ff;
            if (den_ff == 32'd0) begin
               rsp_fmc_ff <= pmc_ff;
               rsp_fms_ff <= pms_ff;
               rsp_fv_ff  <= '0;
               rsp_sat_ff <= sat_ff;
            end else begin
               rsp_fmc_ff <= fmc_clip_w[31:0];
               rsp_fms_ff <= rd_ff.pair ? fms_clip_w[31:0] : 32'sd0;
               rsp_fv_ff  <= fv_ff;
               rsp_sat_ff <= sat_ff | fmc_clip_w[32] | (rd_ff.pair & fms_clip_w[32]);
            end
         end
         default: ;
      endcase
   end

   // a new transaction is never taken while a result waits
   assert property (@(posedge clock) disable iff (reset) req_tready |-> !rsp_tvalid)
      else $error("input ready while result pending");

   // an accepted item either answers next cycle or starts the sequencer
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid || state_ff != ST_IDLE)
      else $error("accepted transaction dropped");

   // the divider never runs past its quotient width
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> div_cnt_ff < 6'(DIV_STEPS))
      else $error("divider step count overrun");

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the spectral Kalman filter step unit.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import skf_pkg::*;

   localparam int  NUM_BINS    = 256;
   localparam int  CYCLE_LIMIT = 3_000_000;
   localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] S_MIN = 32'h8000_0000;

   typedef struct packed {
      logic signed [31:0] pmc;
      logic signed [31:0] pms;
      logic [30:0]        pvar;
      logic signed [31:0] fmc;
      logic signed [31:0] fms;
      logic [30:0]        fvar;
      logic               sat;
   } step_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [167:0] req_tdata = '0;  // bin, coef_a, coef_b, prior_var, obs_cos, obs_sin, pad
   logic [1:0]   req_tuser = '0;  // op, is_pair
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [191:0] rsp_tdata;       // pmc, pms, pred_var, fmc, fms, filt_var, pad
   logic [0:0]   rsp_tuser;       // saturated
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [30:0]  csr_data = '0;

   // filter state mirror
   logic [30:0]        tau2 = OBS_NOISE_RESET;
   logic               bin_pair   [NUM_BINS];
   logic signed [31:0] bin_a      [NUM_BINS];
   logic signed [31:0] bin_b      [NUM_BINS];
   logic [30:0]        bin_spec   [NUM_BINS];
   logic [30:0]        bin_var    [NUM_BINS];
   logic signed [31:0] bin_mc     [NUM_BINS];
   logic signed [31:0] bin_ms     [NUM_BINS];
   bit                 bin_loaded [NUM_BINS];

   step_result_type pending_results[$];
   int  mismatches = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  sat_seen = 0;
   int  cycles = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;

   spectral_kalman_filter_step_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** spectral_kalman_filter_step_unit: FAILED **");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

   function automatic logic signed [31:0] clip32(logic signed [127:0] v, inout logic sat);
      if (v > $signed({96'd0, S_MAX})) begin
         sat = 1'b1;
         return S_MAX;
      end
      if (v < -$signed(128'h8000_0000)) begin
         sat = 1'b1;
         return S_MIN;
      end
      return v[31:0];
   endfunction

   // m1 + r1*(w-m1)/den, rounded half away from zero
   function automatic logic signed [31:0] correct_mean(logic signed [31:0] m1,
         logic signed [31:0] w, logic [127:0] r1, logic [127:0] den, inout logic sat);
      logic signed [127:0] innov;
      logic [127:0] mag, q;
      innov = $signed(w) - $signed(m1);
      mag = (innov < 0) ? -innov : innov;
      q = (r1 * mag + den / 2) / den;
      return clip32((innov < 0) ? $signed(m1) - $signed(q) : $signed(m1) + $signed(q), sat);
   endfunction

   function automatic step_result_type kalman_step(logic op, logic [7:0] bin, logic pair_in,
         logic signed [31:0] a_in, logic signed [31:0] b_in, logic [30:0] pv,
         logic signed [31:0] w_cos, logic signed [31:0] w_sin);
      step_result_type res;
      logic signed [127:0] a, b, mc, ms, pc, ps;
      logic [127:0] g, prod, r1, den, fv;
      logic pair, sat;
      res = '0;
      sat = 1'b0;
      if (op == OP_LOAD) begin
         bin_pair[bin] = pair_in;
         bin_a[bin] = a_in;
         bin_b[bin] = b_in;
         bin_spec[bin] = pv;
         bin_var[bin] = pv;
         bin_mc[bin] = '0;
         bin_ms[bin] = '0;
         bin_loaded[bin] = 1'b1;
         res.fvar = pv;
         return res;
      end
      pair = bin_pair[bin];
      a = bin_a[bin];
      b = pair ? bin_b[bin] : 0;
      mc = bin_mc[bin];
      ms = pair ? bin_ms[bin] : 0;
      pc = (a * mc + b * ms + (1 << 15)) >>> 16;
      ps = (a * ms - b * mc + (1 << 15)) >>> 16;
      res.pmc = clip32(pc, sat);
      res.pms = pair ? clip32(ps, sat) : 0;
      g = a * a + b * b;
      prod = (bin_var[bin] * g + (128'd1 << 31)) >> 32;
      if (prod > VAR_MAX) begin
         prod = VAR_MAX;
         sat = 1'b1;
      end
      r1 = prod + bin_spec[bin];
      if (r1 > VAR_MAX) begin
         r1 = VAR_MAX;
         sat = 1'b1;
      end
      den = r1 + tau2;
      fv = (den == 0) ? 0 : (r1 * tau2 + den / 2) / den;
      res.fmc = (den == 0) ? res.pmc : correct_mean(res.pmc, w_cos, r1, den, sat);
      res.fms = !pair ? 0 : (den == 0) ? res.pms : correct_mean(res.pms, w_sin, r1, den, sat);
      res.pvar = r1[30:0];
      res.fvar = fv[30:0];
      res.sat = sat;
      bin_mc[bin] = res.fmc;
      bin_ms[bin] = res.fms;
      bin_var[bin] = fv[30:0];
      return res;
   endfunction

   always @(posedge clock) begin
      step_result_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pmc  = rsp_tdata[31:0];
         got.pms  = rsp_tdata[63:32];
         got.pvar = rsp_tdata[94:64];
         got.fmc  = rsp_tdata[126:95];
         got.fms  = rsp_tdata[158:127];
         got.fvar = rsp_tdata[189:159];
         got.sat  = rsp_tuser[0];
         results_seen++;
         if (got.sat) sat_seen++;
         if (pending_results.size() == 0) begin
            $error("unexpected result transaction %h", rsp_tdata);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (got.pmc !== want.pmc) begin
               $error("pred_mean_cos exp %h got %h", want.pmc, got.pmc); mismatches++;
            end
            if (got.pms !== want.pms) begin
               $error("pred_mean_sin exp %h got %h", want.pms, got.pms); mismatches++;
            end
            if (got.pvar !== want.pvar) begin
               $error("pred_var exp %h got %h", want.pvar, got.pvar); mismatches++;
            end
            if (got.fmc !== want.fmc) begin
               $error("filt_mean_cos exp %h got %h", want.fmc, got.fmc); mismatches++;
            end
            if (got.fms !== want.fms) begin
               $error("filt_mean_sin exp %h got %h", want.fms, got.fms); mismatches++;
            end
            if (got.fvar !== want.fvar) begin
               $error("filt_var exp %h got %h", want.fvar, got.fvar); mismatches++;
            end
            if (got.sat !== want.sat) begin
               $error("saturated exp %b got %b", want.sat, got.sat); mismatches++;
            end
         end
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_item(logic op, logic [7:0] bin, logic pair, logic [31:0] a,
         logic [31:0] b, logic [30:0] pv, logic [31:0] wc, logic [31:0] ws);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata = {1'b0, ws, wc, pv, b, a, bin};
      req_tuser = {pair, op};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(kalman_step(op, bin, pair, a, b, pv, wc, ws));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_noise_var(logic [30:0] value);
      drain();
      csr_data = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      tau2 = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [31:0] rand_coef();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return $urandom_range(0, 163840) - 81920;  // roughly +-1.25
   endfunction

   function automatic logic [31:0] rand_obs();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
   endfunction

   function automatic logic [30:0] rand_var();
      if ($urandom_range(0, 9) == 0) return 31'($urandom);
      return 31'($urandom_range(0, 32'h0004_0000));
   endfunction

   task automatic test_load_extremes();
      send_item(OP_LOAD, 8'd0, 1'b1, S_MAX, S_MIN, VAR_MAX, $urandom, $urandom);
      send_item(OP_LOAD, 8'd255, 1'b0, S_MIN, S_MAX, 31'd0, S_MAX, S_MIN);
      send_item(OP_LOAD, 8'd1, 1'b1, 32'h0001_0000, 32'h0, 31'h0001_0000, 32'd0, 32'd0);
      send_item(OP_LOAD, 8'd2, 1'b0, 32'hFFFF_8000, 32'hFFFF_FFFF, 31'h100, 32'd0, 32'd0);
   endtask

   task automatic test_observe_extremes();
      // huge coefficients and observations drive the clip paths
      send_item(OP_OBSERVE, 8'd0, 1'($urandom), $urandom, $urandom, 31'($urandom),
                S_MAX, S_MIN);
      send_item(OP_OBSERVE, 8'd0, 1'($urandom), $urandom, $urandom, 31'($urandom),
                S_MIN, S_MAX);
      send_item(OP_OBSERVE, 8'd0, 1'($urandom), $urandom, $urandom, 31'($urandom),
                S_MAX, S_MAX);
      send_item(OP_OBSERVE, 8'd1, 1'b0, 32'd0, 32'd0, 31'd0, 32'h0002_0000, 32'hFFFE_0000);
      send_item(OP_OBSERVE, 8'd1, 1'b0, 32'd0, 32'd0, 31'd0, 32'hFFFF_0001, 32'h0000_7FFF);
      send_item(OP_OBSERVE, 8'd1, 1'b0, 32'd0, 32'd0, 31'd0, S_MIN, S_MAX);
   endtask

   task automatic test_real_bins();
      // sine side ignored for a real bin
      send_item(OP_OBSERVE, 8'd255, 1'b1, 32'd0, 32'd0, 31'd0, S_MAX, S_MAX);
      send_item(OP_OBSERVE, 8'd255, 1'b0, 32'd0, 32'd0, 31'd0, S_MIN, 32'h1234_5678);
      send_item(OP_OBSERVE, 8'd2, 1'b1, 32'd0, 32'd0, 31'd0, 32'h0003_0000, S_MIN);
      send_item(OP_OBSERVE, 8'd2, 1'b0, 32'd0, 32'd0, 31'd0, 32'hFFFD_0000, S_MAX);
      send_item(OP_LOAD, 8'd2, 1'b0, 32'h0, $urandom, 31'h0, 32'd0, 32'd0);
      send_item(OP_OBSERVE, 8'd2, 1'b1, 32'd0, 32'd0, 31'd0, 32'h0000_8000, 32'd0);
   endtask

   task automatic test_random_traffic(int count, int s_idle, int r_idle);
      logic [7:0] bin;
      logic op;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      for (int i = 0; i < count; i++) begin
         bin = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
         op = ($urandom_range(0, 99) < 80) ? OP_OBSERVE : OP_LOAD;
         if (!bin_loaded[bin]) op = OP_LOAD;
         if (i == count / 2) drain();  // let the pipe run dry once mid-stream
         send_item(op, bin, 1'($urandom), rand_coef(), rand_coef(), rand_var(),
                   rand_obs(), rand_obs());
      end
      send_idle_pct = 0;
      recv_idle_pct = 0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_load_extremes();
      test_observe_extremes();
      test_real_bins();
      write_noise_var(31'd1);
      test_random_traffic(280, 11, 74);
      write_noise_var(VAR_MAX);
      test_random_traffic(280, 74, 11);
      write_noise_var(31'($urandom_range(1, 32'h0004_0000)));
      test_random_traffic(275, 0, 0);
      drain();
      repeat (20) @(negedge clock);
      $display("Covered %0d items (loads, real and pair observes), %0d results, %0d saturated,",
               items_sent, results_seen, sat_seen);
      $display("noise variance at reset, minimum, maximum and a random value.");
      if (mismatches == 0 && pending_results.size() == 0)
         $display("** spectral_kalman_filter_step_unit: PASSED **");
      else
         $display("** spectral_kalman_filter_step_unit: FAILED **");
      $finish;
   end

endmodule
`default_nettype wire
